[design/atrp_pkg.sv]
// Package for the AT response parser: payload structs, status codes,
// parser state encoding and character constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atrp_pkg;

    localparam int MAX_LINES_DEF  = 8;
    localparam int LINE_CHARS_DEF = 64;

    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_OK       = 2'd1,
        ST_ERROR    = 2'd2
    } t_status;

    // recogniser states, one-hot
    typedef enum logic [17:0] {
        PS_IDLE   = 18'h00001,
        PS_LF1    = 18'h00002,
        PS_BODY   = 18'h00004,
        PS_OK_K   = 18'h00008,
        PS_OK_CR  = 18'h00010,
        PS_OK_LF  = 18'h00020,
        PS_ER_R1  = 18'h00040,
        PS_ER_R2  = 18'h00080,
        PS_ER_O   = 18'h00100,
        PS_ER_R3  = 18'h00200,
        PS_ER_CR  = 18'h00400,
        PS_ER_LF  = 18'h00800,
        PS_INFO1  = 18'h01000,
        PS_INFO   = 18'h02000,
        PS_INFO_LF = 18'h04000,
        PS_NEXT   = 18'h08000,
        PS_NX_LF  = 18'h10000,
        PS_NX_SEL = 18'h20000
    } t_pstate;

    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_PR_LO  = 8'h20;
    localparam logic [7:0]  CH_PR_HI  = 8'h7E;
    localparam logic [7:0]  CH_O      = 8'h4F;
    localparam logic [7:0]  CH_K      = 8'h4B;
    localparam logic [7:0]  CH_E      = 8'h45;
    localparam logic [7:0]  CH_R      = 8'h52;
    localparam logic [7:0]  CH_PLUS   = 8'h2B;
    localparam logic [31:0] CMGL_WORD = 32'h434D474C;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       expect_text;
        logic [2:0] read_line;
        logic [5:0] read_pos;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic       ok_flag;
        logic [3:0] lines_stored;
        logic [7:0] read_char;
    } t_out;

endpackage

`default_nettype wire

[design/at_response_parser_core.sv]
// AT response parser top level: recogniser, line bookkeeping and line store memory.
// Depends on atrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (atrp_pkg::t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (atrp_pkg::t_out)
//
//  One request per cycle unless a result is stalled. Each result is registered and shows
//  in the cycle after acceptance; read data comes from the store's registered read port.
//  The store is written at the accepting edge of a feed request, so a later read
//  request always sees it; the same entry is never read and written in one cycle.
//  A stalled result holds; the next request is taken in the cycle it is drained.
//  Reset is synchronous; the line store needs no clearing pass (lengths gate reads).

module at_response_parser_core #(
    parameter int MAX_LINES  = atrp_pkg::MAX_LINES_DEF,
    parameter int LINE_CHARS = atrp_pkg::LINE_CHARS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  atrp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output atrp_pkg::t_out o_out_data
);

    localparam int LIW   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CNTW  = $clog2(MAX_LINES + 1);
    localparam int LENW  = $clog2(LINE_CHARS + 1);
    localparam int DEPTH = MAX_LINES * LINE_CHARS;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];

    atrp_pkg::t_pstate r_state, n_state;
    logic [CNTW-1:0]   r_line_count;
    logic [LENW-1:0]   r_len [MAX_LINES];
    logic              r_cmgl [MAX_LINES];
    logic [23:0]       r_recent, n_recent;
    logic              r_ok, n_ok;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic              r_hit;
    logic [7:0]        r_rd_char;

    logic              w_accept, w_feed, w_read;
    logic [7:0]        w_ch;
    atrp_pkg::t_status w_status;
    logic              w_clear, w_put, w_put_zero;
    logic [7:0]        w_put_c;
    logic              w_printable, w_before, w_last;
    logic              w_has_line, w_room, w_is_cmgl;
    logic [LIW-1:0]    w_cur_idx, w_rd_idx;
    logic [LENW-1:0]   w_cur_len;
    logic [AW-1:0]     w_wr_addr, w_rd_addr;
    logic              w_wr_en, w_rd_ok;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_feed     = w_accept && !i_in_data.mode;
    assign w_read     = w_accept && i_in_data.mode;
    assign w_ch       = i_in_data.rx_byte;

    assign w_printable = (w_ch >= atrp_pkg::CH_PR_LO) && (w_ch <= atrp_pkg::CH_PR_HI);

    // current line bookkeeping
    assign w_has_line = 32'(r_line_count) < 32'(MAX_LINES);
    assign w_cur_idx  = LIW'(r_line_count);
    assign w_cur_len  = w_has_line ? r_len[w_cur_idx] : LENW'(0);
    assign w_room     = w_has_line && (32'(w_cur_len) < 32'(LINE_CHARS));
    assign w_wr_addr  = AW'(32'(w_cur_idx) * 32'(LINE_CHARS) + 32'(w_cur_len));
    assign w_is_cmgl  = (32'(w_cur_len) >= 32'd3) && ({r_recent, w_put_c} == atrp_pkg::CMGL_WORD);

    // CMGL flags of the last two closed lines
    assign w_before = (32'(r_line_count) > 32'd1) && r_cmgl[LIW'(r_line_count - CNTW'(2))];
    assign w_last   = (32'(r_line_count) > 32'd0) && r_cmgl[LIW'(r_line_count - CNTW'(1))];

    always_comb begin
        n_state  = r_state;
        n_ok     = r_ok;
        w_status = atrp_pkg::ST_PROGRESS;
        w_clear  = 1'b0;
        w_put    = 1'b0;
        w_put_zero = 1'b0;
        case (r_state)
            atrp_pkg::PS_IDLE: begin
                if (w_ch == atrp_pkg::CH_CR) n_state = atrp_pkg::PS_LF1;
                else w_status = atrp_pkg::ST_ERROR;
            end
            atrp_pkg::PS_LF1: begin
                if (w_ch == atrp_pkg::CH_LF) n_state = atrp_pkg::PS_BODY;
                else w_clear = 1'b1;
            end
            atrp_pkg::PS_BODY: begin
                if (i_in_data.expect_text) begin
                    w_put   = 1'b1;
                    n_state = atrp_pkg::PS_INFO;
                end else if (w_ch == atrp_pkg::CH_O) begin
                    n_state = atrp_pkg::PS_OK_K;
                end else if (w_ch == atrp_pkg::CH_E) begin
                    n_state = atrp_pkg::PS_ER_R1;
                end else if (w_ch == atrp_pkg::CH_PLUS) begin
                    w_put   = 1'b1;
                    n_state = atrp_pkg::PS_INFO1;
                end else begin
                    w_clear = 1'b1;
                end
            end
            atrp_pkg::PS_OK_K: begin
                if (w_ch == atrp_pkg::CH_K) begin
                    n_ok    = 1'b1;
                    n_state = atrp_pkg::PS_OK_CR;
                end else w_clear = 1'b1;
            end
            atrp_pkg::PS_OK_CR: begin
                if (w_ch == atrp_pkg::CH_CR) n_state = atrp_pkg::PS_OK_LF;
                else w_clear = 1'b1;
            end
            atrp_pkg::PS_OK_LF: begin
                if (w_ch == atrp_pkg::CH_LF) begin
                    w_put_zero = 1'b1;
                    n_state    = atrp_pkg::PS_IDLE;
                    w_status   = atrp_pkg::ST_OK;
                end else w_clear = 1'b1;
            end
            atrp_pkg::PS_ER_LF: begin
                // a bad byte here answers error but keeps everything
                if (w_ch == atrp_pkg::CH_LF) begin
                    w_put_zero = 1'b1;
                    n_state    = atrp_pkg::PS_IDLE;
                    w_status   = atrp_pkg::ST_OK;
                end else w_status = atrp_pkg::ST_ERROR;
            end
            atrp_pkg::PS_ER_R1: begin
                if (w_ch == atrp_pkg::CH_R) n_state = atrp_pkg::PS_ER_R2;
                else w_clear = 1'b1;
            end
            atrp_pkg::PS_ER_R2: begin
                if (w_ch == atrp_pkg::CH_R) n_state = atrp_pkg::PS_ER_O;
                else w_status = atrp_pkg::ST_ERROR;
            end
            atrp_pkg::PS_ER_O: begin
                if (w_ch == atrp_pkg::CH_O) n_state = atrp_pkg::PS_ER_R3;
                else w_clear = 1'b1;
            end
            atrp_pkg::PS_ER_R3: begin
                if (w_ch == atrp_pkg::CH_R) begin
                    n_ok    = 1'b0;
                    n_state = atrp_pkg::PS_ER_CR;
                end else w_clear = 1'b1;
            end
            atrp_pkg::PS_ER_CR: begin
                if (w_ch == atrp_pkg::CH_CR) n_state = atrp_pkg::PS_ER_LF;
                else w_clear = 1'b1;
            end
            atrp_pkg::PS_INFO1: begin
                if (w_printable) begin
                    w_put   = 1'b1;
                    n_state = atrp_pkg::PS_INFO;
                end else w_clear = 1'b1;
            end
            atrp_pkg::PS_INFO: begin
                if (w_printable) w_put = 1'b1;
                else if (w_ch == atrp_pkg::CH_CR) n_state = atrp_pkg::PS_INFO_LF;
                else w_clear = 1'b1;
            end
            atrp_pkg::PS_INFO_LF: begin
                if (w_ch == atrp_pkg::CH_LF) begin
                    w_put_zero = 1'b1;
                    n_state    = atrp_pkg::PS_NEXT;
                end else w_clear = 1'b1;
            end
            atrp_pkg::PS_NEXT: begin
                if (w_ch == atrp_pkg::CH_CR) begin
                    n_state = atrp_pkg::PS_NX_LF;
                end else if (w_ch == atrp_pkg::CH_PLUS && !w_before) begin
                    n_state = atrp_pkg::PS_INFO1;
                end else if (w_printable && w_last) begin
                    w_put   = 1'b1;
                    n_state = atrp_pkg::PS_INFO;
                end else w_clear = 1'b1;
            end
            atrp_pkg::PS_NX_LF: begin
                if (w_ch == atrp_pkg::CH_LF) n_state = atrp_pkg::PS_NX_SEL;
                else w_clear = 1'b1;
            end
            atrp_pkg::PS_NX_SEL: begin
                if (w_ch == atrp_pkg::CH_E) n_state = atrp_pkg::PS_ER_R1;
                else if (w_ch == atrp_pkg::CH_O) n_state = atrp_pkg::PS_OK_K;
                else if (w_ch == atrp_pkg::CH_PLUS) n_state = atrp_pkg::PS_INFO;
                else w_clear = 1'b1;
            end
            default: begin
                // unreachable code: drop the store, answer in progress
                w_clear = 1'b1;
            end
        endcase
        if (w_clear) begin
            n_state = atrp_pkg::PS_IDLE;
            if (r_state != atrp_pkg::PS_IDLE && (|(r_state & ~({18{1'b0}} | r_state)) == 1'b0)
                && (r_state == atrp_pkg::PS_IDLE || r_state == atrp_pkg::PS_LF1
                    || r_state == atrp_pkg::PS_BODY || r_state == atrp_pkg::PS_OK_K
                    || r_state == atrp_pkg::PS_OK_CR || r_state == atrp_pkg::PS_OK_LF
                    || r_state == atrp_pkg::PS_ER_R1 || r_state == atrp_pkg::PS_ER_O
                    || r_state == atrp_pkg::PS_ER_R3 || r_state == atrp_pkg::PS_ER_CR
                    || r_state == atrp_pkg::PS_INFO1 || r_state == atrp_pkg::PS_INFO
                    || r_state == atrp_pkg::PS_INFO_LF || r_state == atrp_pkg::PS_NEXT
                    || r_state == atrp_pkg::PS_NX_LF || r_state == atrp_pkg::PS_NX_SEL)) begin
                w_status = atrp_pkg::ST_ERROR;
            end
        end
    end

    // a stored zero closes the line like a line end
    assign w_put_c = w_put_zero ? 8'd0 : w_ch;
    assign w_wr_en = w_feed && !w_clear && (w_put || w_put_zero) && (w_put_c != 8'd0) && w_room;
    assign n_recent = (w_cur_len == LENW'(0)) ? {16'd0, w_put_c} : {r_recent[15:0], w_put_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= atrp_pkg::PS_IDLE;
            r_line_count <= '0;
            r_recent     <= '0;
            r_ok         <= 1'b0;
            for (int i = 0; i < MAX_LINES; i++) begin
                r_len[i]  <= '0;
                r_cmgl[i] <= 1'b0;
            end
        end else if (w_feed) begin
            r_ok <= n_ok;
            if (w_clear) begin
                r_state      <= atrp_pkg::PS_IDLE;
                r_line_count <= '0;
                r_recent     <= '0;
                for (int i = 0; i < MAX_LINES; i++) begin
                    r_len[i]  <= '0;
                    r_cmgl[i] <= 1'b0;
                end
            end else begin
                r_state <= n_state;
                if ((w_put || w_put_zero) && w_put_c == 8'd0) begin
                    if (w_has_line) r_line_count <= r_line_count + CNTW'(1);
                end else if (w_wr_en) begin
                    r_len[w_cur_idx] <= w_cur_len + LENW'(1);
                    r_recent         <= n_recent;
                    if (w_is_cmgl) r_cmgl[w_cur_idx] <= 1'b1;
                end
            end
        end
    end

    // read request: gate on line length, fetch from the store
    assign w_rd_idx  = LIW'(i_in_data.read_line);
    assign w_rd_ok   = (32'(i_in_data.read_line) < 32'(MAX_LINES))
                    && (32'(i_in_data.read_pos) < 32'(LINE_CHARS))
                    && (32'(i_in_data.read_pos) < 32'(r_len[w_rd_idx]));
    assign w_rd_addr = AW'(32'(w_rd_idx) * 32'(LINE_CHARS) + 32'(i_in_data.read_pos));

    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_wr_addr] <= w_put_c;
        if (w_read) r_rd_char <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= i_in_data.mode ? atrp_pkg::ST_PROGRESS : w_status;
            r_hit    <= i_in_data.mode && w_rd_ok;
        end
    end

    // ok flag and line count are only updated at an accepting edge, so they
    // remain the post-request values while a result waits
    assign o_out_valid             = r_out_valid;
    assign o_out_data.status       = r_status;
    assign o_out_data.ok_flag      = r_ok;
    assign o_out_data.lines_stored = 4'(r_line_count);
    assign o_out_data.read_char    = r_hit ? r_rd_char : 8'd0;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_line_count) <= 32'(MAX_LINES))
        else $error("line count beyond limit");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_cur_len) <= 32'(LINE_CHARS))
        else $error("line length beyond limit");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while result stalled");

    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_read |=> (o_out_valid && o_out_data.status == atrp_pkg::ST_PROGRESS))
        else $error("read request gave a ready status");

    a_char_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.read_char != 8'd0)
        |-> o_out_data.status == atrp_pkg::ST_PROGRESS)
        else $error("character returned with a feed result");

endmodule

`default_nettype wire

[sim/at_response_parser_core_test.sv]
// Self-checking bench for at_response_parser_core: framed modem responses, text bodies,
// listing lines, noise and line store reads, checked against an in-bench parser model.
// Depends on atrp_pkg and the at_response_parser_core RTL.
`timescale 1ns / 1ps

module at_response_parser_core_test;

    import atrp_pkg::*;

    localparam int MAX_LINES  = MAX_LINES_DEF;
    localparam int LINE_CHARS = LINE_CHARS_DEF;

    localparam logic MODE_FEED = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam int HOLD_CYCLES = 300;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    // parser model state
    t_pstate     parse_st;
    logic [7:0]  line_buf [MAX_LINES][LINE_CHARS];
    int          line_fill [MAX_LINES];
    bit          line_is_list [MAX_LINES];
    logic [23:0] tail3;
    int          lines_done;
    bit          ok_latched;

    t_in  req_pending [$];
    t_out resp_due [$];
    int   n_queued = 0;
    int   n_errors = 0;
    bit   req_taken = 1'b0;

    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int read_mix_pct  = 0;
    int corrupt_permil = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    at_response_parser_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("at_response_parser_core_test: errors");
        $finish;
    end

    // ---------------------------------------------------------------- parser model

    function automatic void wipe_lines();
        parse_st = PS_IDLE;
        for (int i = 0; i < MAX_LINES; i++) begin
            line_fill[i] = 0;
            line_is_list[i] = 1'b0;
        end
        tail3 = '0;
        lines_done = 0;
    endfunction

    function automatic t_status wipe_and_fail();
        wipe_lines();
        return ST_ERROR;
    endfunction

    function automatic bit is_print(logic [7:0] c);
        return c >= CH_PR_LO && c <= CH_PR_HI;
    endfunction

    // zero closes the line; otherwise append, dropping when full
    function automatic void line_append(logic [7:0] c);
        int n;
        if (c == 8'h00) begin
            if (lines_done < MAX_LINES)
                lines_done++;
            return;
        end
        if (lines_done >= MAX_LINES)
            return;
        n = line_fill[lines_done];
        if (n >= LINE_CHARS)
            return;
        line_buf[lines_done][n] = c;
        if (n >= 3 && {tail3, c} == CMGL_WORD)
            line_is_list[lines_done] = 1'b1;
        tail3 = (n == 0) ? {16'h0000, c} : {tail3[15:0], c};
        line_fill[lines_done] = n + 1;
    endfunction

    function automatic t_status parse_byte(logic [7:0] ch, bit text);
        bit last_list;
        bit prev_list;
        case (parse_st)
            PS_IDLE: begin
                if (ch != CH_CR)
                    return ST_ERROR;
                parse_st = PS_LF1;
            end
            PS_LF1: begin
                if (ch != CH_LF)
                    return wipe_and_fail();
                parse_st = PS_BODY;
            end
            PS_BODY: begin
                if (text) begin
                    line_append(ch);
                    parse_st = PS_INFO;
                end else if (ch == CH_O) begin
                    parse_st = PS_OK_K;
                end else if (ch == CH_E) begin
                    parse_st = PS_ER_R1;
                end else if (ch == CH_PLUS) begin
                    line_append(ch);
                    parse_st = PS_INFO1;
                end else begin
                    return wipe_and_fail();
                end
            end
            PS_OK_K: begin
                if (ch != CH_K)
                    return wipe_and_fail();
                ok_latched = 1'b1;
                parse_st = PS_OK_CR;
            end
            PS_OK_CR: begin
                if (ch != CH_CR)
                    return wipe_and_fail();
                parse_st = PS_OK_LF;
            end
            PS_OK_LF, PS_ER_LF: begin
                if (ch == CH_LF) begin
                    line_append(8'h00);
                    parse_st = PS_IDLE;
                    return ST_OK;
                end
                // a bad byte after ERROR's CR keeps everything
                if (parse_st == PS_ER_LF)
                    return ST_ERROR;
                return wipe_and_fail();
            end
            PS_ER_R1: begin
                if (ch != CH_R)
                    return wipe_and_fail();
                parse_st = PS_ER_R2;
            end
            PS_ER_R2: begin
                if (ch != CH_R)
                    return ST_ERROR;
                parse_st = PS_ER_O;
            end
            PS_ER_O: begin
                if (ch != CH_O)
                    return wipe_and_fail();
                parse_st = PS_ER_R3;
            end
            PS_ER_R3: begin
                if (ch != CH_R)
                    return wipe_and_fail();
                ok_latched = 1'b0;
                parse_st = PS_ER_CR;
            end
            PS_ER_CR: begin
                if (ch != CH_CR)
                    return wipe_and_fail();
                parse_st = PS_ER_LF;
            end
            PS_INFO1: begin
                if (!is_print(ch))
                    return wipe_and_fail();
                line_append(ch);
                parse_st = PS_INFO;
            end
            PS_INFO: begin
                if (is_print(ch))
                    line_append(ch);
                else if (ch == CH_CR)
                    parse_st = PS_INFO_LF;
                else
                    return wipe_and_fail();
            end
            PS_INFO_LF: begin
                if (ch != CH_LF)
                    return wipe_and_fail();
                line_append(8'h00);
                parse_st = PS_NEXT;
            end
            PS_NEXT: begin
                prev_list = (lines_done > 1) ? line_is_list[lines_done - 2] : 1'b0;
                last_list = (lines_done > 0) ? line_is_list[lines_done - 1] : 1'b0;
                if (ch == CH_CR) begin
                    parse_st = PS_NX_LF;
                end else if (ch == CH_PLUS && !prev_list) begin
                    parse_st = PS_INFO1;
                end else if (is_print(ch) && last_list) begin
                    line_append(ch);
                    parse_st = PS_INFO;
                end else begin
                    return wipe_and_fail();
                end
            end
            PS_NX_LF: begin
                if (ch != CH_LF)
                    return wipe_and_fail();
                parse_st = PS_NX_SEL;
            end
            PS_NX_SEL: begin
                if (ch == CH_E)
                    parse_st = PS_ER_R1;
                else if (ch == CH_O)
                    parse_st = PS_OK_K;
                else if (ch == CH_PLUS)
                    parse_st = PS_INFO;
                else
                    return wipe_and_fail();
            end
            default: begin
                wipe_lines();
            end
        endcase
        return ST_PROGRESS;
    endfunction

    function automatic t_out predict_response(t_in r);
        t_out    o;
        t_status st;
        logic [7:0] rc;
        st = ST_PROGRESS;
        rc = 8'h00;
        if (r.mode == MODE_FEED)
            st = parse_byte(r.rx_byte, r.expect_text);
        else if (int'(r.read_line) < MAX_LINES && int'(r.read_pos) < line_fill[r.read_line])
            rc = line_buf[r.read_line][r.read_pos];
        o.status       = st;
        o.ok_flag      = ok_latched;
        o.lines_stored = 4'(lines_done);
        o.read_char    = rc;
        return o;
    endfunction

    // ---------------------------------------------------------------- request builders

    task automatic push_read(input logic [2:0] ln, input logic [5:0] pos);
        t_in r;
        r.mode        = MODE_READ;
        r.rx_byte     = 8'($urandom_range(255));
        r.expect_text = 1'($urandom_range(1));
        r.read_line   = ln;
        r.read_pos    = pos;
        req_pending.push_back(r);
        n_queued++;
    endtask

    task automatic push_byte(input logic [7:0] ch, input bit text);
        t_in r;
        if ($urandom_range(99) < read_mix_pct)
            push_read(3'($urandom_range(7)),
                      6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7)));
        r.mode        = MODE_FEED;
        r.rx_byte     = ($urandom_range(999) < corrupt_permil) ? 8'($urandom_range(255)) : ch;
        r.expect_text = text;
        r.read_line   = 3'($urandom_range(7));
        r.read_pos    = 6'($urandom_range(63));
        req_pending.push_back(r);
        n_queued++;
    endtask

    task automatic push_crlf();
        push_byte(CH_CR, 1'($urandom_range(1)));
        push_byte(CH_LF, 1'($urandom_range(1)));
    endtask

    // OK or ERROR word with its closing CR LF
    task automatic push_status_word(input bit is_ok);
        if (is_ok) begin
            push_byte(CH_O, 1'b0);
            push_byte(CH_K, 1'($urandom_range(1)));
        end else begin
            push_byte(CH_E, 1'b0);
            push_byte(CH_R, 1'($urandom_range(1)));
            push_byte(CH_R, 1'($urandom_range(1)));
            push_byte(CH_O, 1'($urandom_range(1)));
            push_byte(CH_R, 1'($urandom_range(1)));
        end
        push_crlf();
    endtask

    task automatic push_line_text(input int n, input bit with_list);
        if (with_list) begin
            push_byte(CMGL_WORD[31:24], 1'($urandom_range(1)));
            push_byte(CMGL_WORD[23:16], 1'($urandom_range(1)));
            push_byte(CMGL_WORD[15:8], 1'($urandom_range(1)));
            push_byte(CMGL_WORD[7:0], 1'($urandom_range(1)));
        end
        repeat (n)
            push_byte(8'($urandom_range(CH_PR_HI, CH_PR_LO)), 1'($urandom_range(1)));
        push_crlf();
    endtask

    // '+' lines, continuation lines after a listing line, then the final status
    task automatic push_info(input int n_lines, input int lo, input int hi, input int list_pct);
        bit last_list;
        bit prev_list;
        bit c;
        push_crlf();
        push_byte(CH_PLUS, 1'b0);
        c = ($urandom_range(99) < list_pct);
        push_line_text($urandom_range(hi, lo), c);
        prev_list = 1'b0;
        last_list = c;
        for (int i = 1; i < n_lines; i++) begin
            c = ($urandom_range(99) < list_pct);
            if (last_list && $urandom_range(1)) begin
                push_line_text($urandom_range(hi, lo), c);
            end else if (!prev_list) begin
                push_byte(CH_PLUS, 1'($urandom_range(1)));
                push_line_text($urandom_range(hi, lo), c);
            end else begin
                break;
            end
            prev_list = last_list;
            last_list = c;
        end
        push_crlf();
        if ($urandom_range(3) == 0) begin
            push_byte(CH_PLUS, 1'($urandom_range(1)));
            push_line_text($urandom_range(6), 1'b0);
            push_crlf();
        end
        push_status_word(1'($urandom_range(1)));
    endtask

    task automatic push_random_traffic(input int goal);
        int stop;
        int kind;
        stop = n_queued + goal;
        while (n_queued < stop) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                push_crlf();
                push_status_word(1'b1);
            end else if (kind < 32) begin
                push_crlf();
                push_status_word(1'b0);
            end else if (kind < 64) begin
                push_info($urandom_range(3, 1), 1, 10, 35);
            end else if (kind < 78) begin
                // free text body; the first byte may be anything, zero included
                push_crlf();
                push_byte(8'($urandom_range(255)), 1'b1);
                push_line_text($urandom_range(12), 1'b0);
                push_crlf();
                push_status_word(1'($urandom_range(1)));
            end else if (kind < 90) begin
                repeat ($urandom_range(6, 1))
                    push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (kind < 95) begin
                // enough lines to saturate the line count
                push_info($urandom_range(11, 9), 1, 3, 0);
            end else begin
                // overlong lines saturate the line length
                push_info($urandom_range(2, 1), 60, 72, 20);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (req_pending.size() != 0 || in_valid || resp_due.size() != 0);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic note_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    endtask

    always @(posedge clk) begin : mon
        t_out want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (resp_due.size() == 0) begin
                    note_mismatch("result with no request due", out_data, 0);
                end else begin
                    want = resp_due.pop_front();
                    if (out_data.status !== want.status)
                        note_mismatch("status", out_data.status, want.status);
                    if (out_data.ok_flag !== want.ok_flag)
                        note_mismatch("ok_flag", out_data.ok_flag, want.ok_flag);
                    if (out_data.lines_stored !== want.lines_stored)
                        note_mismatch("lines_stored", out_data.lines_stored, want.lines_stored);
                    if (out_data.read_char !== want.read_char)
                        note_mismatch("read_char", out_data.read_char, want.read_char);
                end
            end
            if (in_valid && in_ready)
                resp_due.push_back(predict_response(in_data));
            req_taken <= in_valid && in_ready;
        end else begin
            req_taken <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- driving

    always @(negedge clk) begin
        if (rst_n && (!in_valid || req_taken)) begin
            if (req_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= req_pending.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial begin
        wipe_lines();
        ok_latched = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        snd_idle_pct = 14;
        rcv_idle_pct = 61;

        // directed: byte and field extremes, both request kinds, keep-store errors
        push_byte(8'hFF, 1'b1);
        push_read(3'd7, 6'd63);
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_crlf();
        push_crlf();
        push_status_word(1'b1);
        push_crlf();
        push_byte(CH_E, 1'b0);
        push_byte(CH_R, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(CH_R, 1'b0);
        push_byte(CH_O, 1'b0);
        push_byte(CH_R, 1'b0);
        push_byte(CH_CR, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_read(3'd0, 6'd0);
        wait_drained();

        read_mix_pct   = 12;
        corrupt_permil = 15;
        push_random_traffic(330);
        wait_drained();

        snd_idle_pct = 61;
        rcv_idle_pct = 14;
        push_random_traffic(330);
        // long receiver hold-off with requests still queued
        hold_req = 1'b1;
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        push_random_traffic(330);
        wait_drained();

        repeat (10) @(posedge clk);
        if (resp_due.size() != 0)
            note_mismatch("results still due", resp_due.size(), 0);
        if (n_errors == 0)
            $display("at_response_parser_core_test: clean");
        else
            $display("at_response_parser_core_test: errors");
        $finish;
    end

endmodule
